### hdl/bht_pkg.sv
// Shared types, constants and saturation helper for the bone hierarchy transform.
package bht_pkg;

    localparam int MAX_BONES_DEF = 128;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAT_WORDS     = 12;
    localparam int TAG_W         = 6;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
        logic [7:0]         parent_index;
        logic               last_bone;
    } item_t;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m03;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m13;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
        logic signed [31:0] m23;
    } result_t;

    // request/response side-band of the shared multiplier
    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
    } mul_ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi)
            return 32'sh7fffffff;
        else if (v < lo)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

### hdl/bht_mul.sv
// Shared fixed-point multiplier: round half up, saturate, one register stage.
module bht_mul
    import bht_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    input  mul_ctl_t           ctl_in,
    output logic signed [31:0] res,
    output mul_ctl_t           ctl_out
);

    logic signed [63:0] prod;
    logic signed [65:0] rounded;
    logic signed [65:0] shifted;
    logic signed [31:0] res_next;
    logic signed [31:0] res_reg;
    mul_ctl_t           ctl_reg;

    always_comb
    begin
        prod     = a * b;
        rounded  = 66'(prod) + (66'sd1 <<< (FRAC_BITS - 1));
        // arithmetic shift floors, matching the reference rounding
        shifted  = rounded >>> FRAC_BITS;
        res_next = sat32(shifted);
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    assign res     = res_reg;
    assign ctl_out = ctl_reg;

endmodule

### hdl/bone_hierarchy_transform.sv
// Skeleton forward kinematics: bones in index order, one global matrix out per bone.
//
// Input channel item_valid / item_stall / item carries one bone per transfer: local
// translation, rotation quaternion, scale (signed fixed point), parent index and a
// last-bone flag. The output channel result_valid / result_stall / result carries
// the top three rows of the bone's global matrix, one transfer per input transfer.
// Bones are processed one at a time on a single shared multiplier under a small
// sequencer: 9 quaternion products, 9 scaled rotation terms, then for a child bone
// 36 products against the parent matrix read from the on-chip matrix store.
// item_stall is low only while idle, so with a free output register the next bone is
// taken in the same cycle that the result appears.
// The finished result sits in an output register; a new bone is taken while it
// waits, but that bone's result is held back until the register is free, so a
// stalled receiver simply holds the block.
// Reset clears the bone counter and handshake state; the matrix store is not
// cleared, and a parent is read only after it has been written this skeleton.
module bone_hierarchy_transform
    import bht_pkg::*;
#(
    parameter int MAX_BONES = MAX_BONES_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int DEPTH = MAX_BONES * MAT_WORDS;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_QUAT = 3'd1;
    localparam logic [2:0] S_LOC  = 3'd2;
    localparam logic [2:0] S_GLOB = 3'd3;
    localparam logic [2:0] S_ROOT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]         state_reg;
    logic [3:0]         cnt_reg;
    logic [1:0]         ii_reg;
    logic [1:0]         jj_reg;
    logic [1:0]         kk_reg;
    logic               gdone_reg;
    logic [BW-1:0]      cur_reg;
    logic               child_reg;
    item_t              item_reg;
    logic signed [31:0] q_reg [9];
    logic signed [31:0] l_reg [9];
    logic signed [31:0] p_reg [MAT_WORDS];
    logic signed [31:0] g_reg [MAT_WORDS];
    logic signed [35:0] acc_reg;
    logic               out_valid_reg;
    result_t            out_reg;

    logic [3:0]         ld_cnt_reg;
    logic               ld_pend_reg;
    logic [3:0]         ld_idx_reg;
    logic signed [31:0] rd_data_reg;
    logic signed [31:0] mem [DEPTH];

    logic               accept;
    logic signed [31:0] pos [3];
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    mul_ctl_t           mul_req;
    logic signed [31:0] mul_res;
    mul_ctl_t           mul_rsp;
    logic [1:0]         ri;
    logic [1:0]         rj;
    logic [1:0]         rk;
    logic signed [35:0] gsum;
    logic signed [35:0] gtot;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic [12:0]        wr_full;
    logic [12:0]        rd_full;
    logic [3:0]         root_row;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != S_IDLE);

    assign pos[0] = item_reg.pos_x;
    assign pos[1] = item_reg.pos_y;
    assign pos[2] = item_reg.pos_z;

    // rotation matrix element from the quaternion products
    // product order: xx yy zz xy xz yz wx wy wz
    function automatic logic signed [31:0] rot(input logic [3:0] idx);
        logic signed [34:0] one;
        logic signed [34:0] t;
        one = 35'sd1 <<< FRAC_BITS;
        case (idx)
            4'd0:    t = one - ((35'(q_reg[1]) + 35'(q_reg[2])) <<< 1);
            4'd1:    t = (35'(q_reg[3]) - 35'(q_reg[8])) <<< 1;
            4'd2:    t = (35'(q_reg[4]) + 35'(q_reg[7])) <<< 1;
            4'd3:    t = (35'(q_reg[3]) + 35'(q_reg[8])) <<< 1;
            4'd4:    t = one - ((35'(q_reg[0]) + 35'(q_reg[2])) <<< 1);
            4'd5:    t = (35'(q_reg[5]) - 35'(q_reg[6])) <<< 1;
            4'd6:    t = (35'(q_reg[4]) - 35'(q_reg[7])) <<< 1;
            4'd7:    t = (35'(q_reg[5]) + 35'(q_reg[6])) <<< 1;
            default: t = one - ((35'(q_reg[0]) + 35'(q_reg[1])) <<< 1);
        endcase
        return sat32(66'(t));
    endfunction

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_req = '0;
        case (state_reg)
            S_QUAT:
            begin
                mul_req.valid = (cnt_reg < 4'd9);
                mul_req.tag   = TAG_W'(cnt_reg);
                case (cnt_reg)
                    4'd0:    begin mul_a = item_reg.quat_x; mul_b = item_reg.quat_x; end
                    4'd1:    begin mul_a = item_reg.quat_y; mul_b = item_reg.quat_y; end
                    4'd2:    begin mul_a = item_reg.quat_z; mul_b = item_reg.quat_z; end
                    4'd3:    begin mul_a = item_reg.quat_x; mul_b = item_reg.quat_y; end
                    4'd4:    begin mul_a = item_reg.quat_x; mul_b = item_reg.quat_z; end
                    4'd5:    begin mul_a = item_reg.quat_y; mul_b = item_reg.quat_z; end
                    4'd6:    begin mul_a = item_reg.quat_w; mul_b = item_reg.quat_x; end
                    4'd7:    begin mul_a = item_reg.quat_w; mul_b = item_reg.quat_y; end
                    default: begin mul_a = item_reg.quat_w; mul_b = item_reg.quat_z; end
                endcase
            end
            S_LOC:
            begin
                mul_req.valid = (cnt_reg < 4'd9);
                mul_req.tag   = TAG_W'(cnt_reg);
                mul_a         = rot(cnt_reg);
                if (cnt_reg inside {4'd0, 4'd3, 4'd6})
                    mul_b = item_reg.scale_x;
                else if (cnt_reg inside {4'd1, 4'd4, 4'd7})
                    mul_b = item_reg.scale_y;
                else
                    mul_b = item_reg.scale_z;
            end
            S_GLOB:
            begin
                mul_req.valid = !gdone_reg;
                mul_req.tag   = {ii_reg, jj_reg, kk_reg};
                mul_a         = p_reg[{ii_reg, kk_reg}];
                if (jj_reg == 2'd3)
                    mul_b = pos[kk_reg];
                else
                    mul_b = l_reg[4'(kk_reg) * 4'd3 + 4'(jj_reg)];
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    bht_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .a       (mul_a),
        .b       (mul_b),
        .ctl_in  (mul_req),
        .res     (mul_res),
        .ctl_out (mul_rsp)
    );

    assign ri = mul_rsp.tag[5:4];
    assign rj = mul_rsp.tag[3:2];
    assign rk = mul_rsp.tag[1:0];

    // accumulation of one global element; translation column adds the parent offset
    always_comb
    begin
        gsum = ((rk == 2'd0) ? 36'sd0 : acc_reg) + 36'(mul_res);
        gtot = gsum + ((rj == 2'd3) ? 36'(p_reg[{ri, 2'd3}]) : 36'sd0);
    end

    assign root_row = (cnt_reg >> 2) * 4'd3 + 4'(cnt_reg[1:0]);

    // matrix store write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_full = 13'(cur_reg) * 13'd12;
        wr_data = '0;
        if (state_reg == S_GLOB && mul_rsp.valid && rk == 2'd2)
        begin
            wr_en   = 1'b1;
            wr_full = 13'(cur_reg) * 13'd12 + 13'({ri, rj});
            wr_data = sat32(66'(gtot));
        end
        else if (state_reg == S_ROOT)
        begin
            wr_en   = 1'b1;
            wr_full = 13'(cur_reg) * 13'd12 + 13'(cnt_reg);
            wr_data = (cnt_reg[1:0] == 2'd3) ? pos[cnt_reg[3:2]] : l_reg[root_row];
        end
        wr_addr = wr_full[AW-1:0];
    end

    assign rd_full = 13'(item_reg.parent_index) * 13'd12 + 13'(ld_cnt_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_full[AW-1:0]];
    end

    // parent fetch runs alongside the quaternion phase and into the scaled-rotation phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_cnt_reg  <= '0;
            ld_pend_reg <= 1'b0;
            ld_idx_reg  <= '0;
        end
        else
        begin
            ld_pend_reg <= 1'b0;
            if (accept)
                ld_cnt_reg <= '0;
            else if (state_reg != S_IDLE && child_reg && ld_cnt_reg < 4'(MAT_WORDS))
            begin
                ld_pend_reg <= 1'b1;
                ld_idx_reg  <= ld_cnt_reg;
                ld_cnt_reg  <= ld_cnt_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_pend_reg)
            p_reg[ld_idx_reg] <= rd_data_reg;
        if (accept)
            item_reg <= item;
        if (state_reg == S_QUAT && mul_rsp.valid)
            q_reg[mul_rsp.tag[3:0]] <= mul_res;
        if (state_reg == S_LOC && mul_rsp.valid)
            l_reg[mul_rsp.tag[3:0]] <= mul_res;
        if (state_reg == S_GLOB && mul_rsp.valid)
        begin
            acc_reg <= gsum;
            if (rk == 2'd2)
                g_reg[{ri, rj}] <= sat32(66'(gtot));
        end
        if (state_reg == S_ROOT)
            g_reg[cnt_reg] <= wr_data;
        if (state_reg == S_OUT && (!out_valid_reg || !result_stall))
        begin
            out_reg.m00 <= g_reg[0];
            out_reg.m01 <= g_reg[1];
            out_reg.m02 <= g_reg[2];
            out_reg.m03 <= g_reg[3];
            out_reg.m10 <= g_reg[4];
            out_reg.m11 <= g_reg[5];
            out_reg.m12 <= g_reg[6];
            out_reg.m13 <= g_reg[7];
            out_reg.m20 <= g_reg[8];
            out_reg.m21 <= g_reg[9];
            out_reg.m22 <= g_reg[10];
            out_reg.m23 <= g_reg[11];
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ii_reg        <= '0;
            jj_reg        <= '0;
            kk_reg        <= '0;
            gdone_reg     <= 1'b0;
            cur_reg       <= '0;
            child_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // in S_OUT the output register is refilled below instead
            if (out_valid_reg && !result_stall && state_reg != S_OUT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_QUAT;
                        cnt_reg   <= '0;
                        child_reg <= (9'(item.parent_index) < 9'(cur_reg));
                    end
                end
                S_QUAT:
                begin
                    if (cnt_reg < 4'd9)
                        cnt_reg <= cnt_reg + 4'd1;
                    if (mul_rsp.valid && mul_rsp.tag == TAG_W'(8))
                    begin
                        state_reg <= S_LOC;
                        cnt_reg   <= '0;
                    end
                end
                S_LOC:
                begin
                    if (cnt_reg < 4'd9)
                        cnt_reg <= cnt_reg + 4'd1;
                    if (mul_rsp.valid && mul_rsp.tag == TAG_W'(8))
                    begin
                        cnt_reg   <= '0;
                        ii_reg    <= '0;
                        jj_reg    <= '0;
                        kk_reg    <= '0;
                        gdone_reg <= 1'b0;
                        state_reg <= child_reg ? S_GLOB : S_ROOT;
                    end
                end
                S_GLOB:
                begin
                    if (!gdone_reg)
                    begin
                        if (kk_reg == 2'd2)
                        begin
                            kk_reg <= '0;
                            if (jj_reg == 2'd3)
                            begin
                                jj_reg <= '0;
                                if (ii_reg == 2'd2)
                                    gdone_reg <= 1'b1;
                                else
                                    ii_reg <= ii_reg + 2'd1;
                            end
                            else
                                jj_reg <= jj_reg + 2'd1;
                        end
                        else
                            kk_reg <= kk_reg + 2'd1;
                    end
                    if (mul_rsp.valid && mul_rsp.tag == {2'd2, 2'd3, 2'd2})
                        state_reg <= S_OUT;
                end
                S_ROOT:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'(MAT_WORDS - 1))
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !result_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (item_reg.last_bone || cur_reg == BW'(MAX_BONES - 1))
                            cur_reg <= '0;
                        else
                            cur_reg <= cur_reg + BW'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_mul_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.valid |-> (state_reg == S_QUAT || state_reg == S_LOC
                           || state_reg == S_GLOB))
        else $error("multiplier result outside a compute phase");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_QUAT)
        else $error("accepted bone did not start the quaternion phase");

    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_full < 13'(DEPTH)))
        else $error("matrix store write out of range");

    a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_reg) < MAX_BONES)
        else $error("bone counter beyond skeleton size");

    a_glob_child: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GLOB) |-> child_reg)
        else $error("parent multiply for a root bone");

endmodule

### test/bone_hierarchy_transform_tb.sv
// Testbench for the bone hierarchy transform: random skeletons checked against a local pose model.
`timescale 1ns / 100ps

module bone_hierarchy_transform_tb
    import bht_pkg::*;
;

    localparam int BONES = MAX_BONES_DEF;
    localparam int FRAC  = FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 600000;

    typedef logic signed [31:0] word_t;
    typedef logic signed [65:0] wide_t;

    class pose_scoreboard;
        word_t   pose_store [BONES][12];
        int      bone_num;
        result_t pending [$];
        int      fail_count;
        int      checked;

        function new();
            bone_num = 0;
            fail_count = 0;
            checked = 0;
        endfunction

        function word_t clamp(wide_t v);
            if (v > 66'sd2147483647)
                return 32'sh7fffffff;
            else if (v < -66'sd2147483648)
                return 32'sh80000000;
            return v[31:0];
        endfunction

        // product rounded half up, then clamped
        function word_t qmul(word_t a, word_t b);
            wide_t p;
            p = wide_t'(a) * wide_t'(b) + (66'sd1 <<< (FRAC - 1));
            return clamp(p >>> FRAC);
        endfunction

        function void note_bone(item_t it);
            word_t xx, yy, zz, xy, xz, yz, wx, wy, wz;
            word_t rot [3][3];
            word_t loc [3][4];
            word_t glob [3][4];
            word_t sc [3];
            word_t ps [3];
            wide_t one, acc;
            result_t res;
            int cur;
            one = 66'sd1 <<< FRAC;
            cur = bone_num;
            sc = '{it.scale_x, it.scale_y, it.scale_z};
            ps = '{it.pos_x, it.pos_y, it.pos_z};
            xx = qmul(it.quat_x, it.quat_x); yy = qmul(it.quat_y, it.quat_y);
            zz = qmul(it.quat_z, it.quat_z); xy = qmul(it.quat_x, it.quat_y);
            xz = qmul(it.quat_x, it.quat_z); yz = qmul(it.quat_y, it.quat_z);
            wx = qmul(it.quat_w, it.quat_x); wy = qmul(it.quat_w, it.quat_y);
            wz = qmul(it.quat_w, it.quat_z);
            rot[0][0] = clamp(one - 2 * (wide_t'(yy) + zz));
            rot[0][1] = clamp(2 * (wide_t'(xy) - wz));
            rot[0][2] = clamp(2 * (wide_t'(xz) + wy));
            rot[1][0] = clamp(2 * (wide_t'(xy) + wz));
            rot[1][1] = clamp(one - 2 * (wide_t'(xx) + zz));
            rot[1][2] = clamp(2 * (wide_t'(yz) - wx));
            rot[2][0] = clamp(2 * (wide_t'(xz) - wy));
            rot[2][1] = clamp(2 * (wide_t'(yz) + wx));
            rot[2][2] = clamp(one - 2 * (wide_t'(xx) + yy));
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                    loc[i][j] = qmul(rot[i][j], sc[j]);
                loc[i][3] = ps[i];
            end
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 4; j++)
                begin
                    if (int'(it.parent_index) < cur)
                    begin
                        acc = 0;
                        for (int k = 0; k < 3; k++)
                            acc += qmul(pose_store[it.parent_index][i * 4 + k], loc[k][j]);
                        if (j == 3)
                            acc += pose_store[it.parent_index][i * 4 + 3];
                        glob[i][j] = clamp(acc);
                    end
                    else
                        glob[i][j] = loc[i][j];
                    pose_store[cur][i * 4 + j] = glob[i][j];
                end
            res = '{glob[0][0], glob[0][1], glob[0][2], glob[0][3],
                    glob[1][0], glob[1][1], glob[1][2], glob[1][3],
                    glob[2][0], glob[2][1], glob[2][2], glob[2][3]};
            pending.push_back(res);
            bone_num = (it.last_bone || cur + 1 >= BONES) ? 0 : cur + 1;
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            word_t ew [12];
            word_t gw [12];
            string nm [12];
            nm = '{"m00", "m01", "m02", "m03", "m10", "m11", "m12", "m13",
                   "m20", "m21", "m22", "m23"};
            if (pending.size() == 0)
            begin
                $error("result with no bone outstanding");
                fail_count++;
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            ew = {>>{exp_r}};
            gw = {>>{got}};
            for (int i = 0; i < 12; i++)
                if (ew[i] !== gw[i])
                begin
                    $error("%s: expected %0d, got %0d", nm[i], ew[i], gw[i]);
                    fail_count++;
                end
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    pose_scoreboard sb = new();
    int src_idle_pct = 0;
    int dst_stall_pct = 0;
    int hold_off = 0;
    int cycles = 0;
    int next_bone = 0;
    int sent = 0;

    bone_hierarchy_transform DUT (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("bone_hierarchy_transform test failed");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);

    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < dst_stall_pct);
    end

    function word_t rand_word();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return word_t'($urandom);
            default: return word_t'($signed($urandom_range(262143)) - 131072);
        endcase
    endfunction

    // near-unit quaternion parts stay within about one
    function word_t rand_unitish();
        return word_t'($signed($urandom_range(131072)) - 65536);
    endfunction

    function item_t make_bone(bit wild, int root_pct, bit end_flag);
        item_t b;
        if (wild)
        begin
            b.pos_x = rand_word(); b.pos_y = rand_word(); b.pos_z = rand_word();
            b.quat_w = rand_word(); b.quat_x = rand_word();
            b.quat_y = rand_word(); b.quat_z = rand_word();
            b.scale_x = rand_word(); b.scale_y = rand_word(); b.scale_z = rand_word();
        end
        else
        begin
            b.pos_x = word_t'($urandom) >>> 8; b.pos_y = word_t'($urandom) >>> 8;
            b.pos_z = word_t'($urandom) >>> 8;
            b.quat_w = rand_unitish(); b.quat_x = rand_unitish();
            b.quat_y = rand_unitish(); b.quat_z = rand_unitish();
            b.scale_x = rand_unitish() * 2; b.scale_y = rand_unitish() * 2;
            b.scale_z = rand_unitish() * 2;
        end
        if ($urandom_range(99) < root_pct || next_bone == 0)
            b.parent_index = ($urandom_range(1)) ? 8'hff : 8'($urandom);
        else
            b.parent_index = 8'($urandom_range(next_bone - 1));
        b.last_bone = end_flag;
        return b;
    endfunction

    // valid stays high after a transfer; the next call or drain() decides its level
    task automatic send_bone(item_t b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item <= b;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_bone(b);
        next_bone = sb.bone_num;
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    initial
    begin
        item_t b;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: identity root, extremes, child chain, out-of-range parent, end flag
        b = '0;
        b.quat_w = 32'sh10000; b.scale_x = 32'sh10000; b.scale_y = 32'sh10000;
        b.scale_z = 32'sh10000; b.pos_x = 32'sh30000; b.parent_index = 8'hff;
        send_bone(b);
        b.parent_index = 8'd0;
        send_bone(b);
        b.parent_index = 8'd5;
        send_bone(b);
        b = '1;
        b.last_bone = 1'b0; b.parent_index = 8'd1;
        send_bone(b);
        b = {{10{32'sh7fffffff}}, 8'd0, 1'b0};
        send_bone(b);
        b = {{10{32'sh80000000}}, 8'd4, 1'b0};
        send_bone(b);
        b = {{10{32'sh80000000}}, 8'd5, 1'b0};
        send_bone(b);
        b = {{3{32'sh7fffffff}}, {7{32'sh80000000}}, 8'd6, 1'b1};
        send_bone(b);
        b = '0;
        b.parent_index = 8'd0;
        send_bone(b);
        b.parent_index = 8'd0; b.last_bone = 1'b1;
        send_bone(b);
        for (int i = 0; i < 8; i++)
            send_bone(make_bone(1'b1, 30, i == 7));
        drain();

        // counter wrap: a full skeleton with no end flag
        for (int i = 0; i < BONES + 3; i++)
            send_bone(make_bone(i % 9 == 0, 15, 1'b0));
        send_bone(make_bone(1'b0, 15, 1'b1));
        drain();

        // long receiver hold-off while bones keep coming
        hold_off = 400;
        for (int i = 0; i < 6; i++)
            send_bone(make_bone(1'b0, 20, 1'b0));
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
                1: begin src_idle_pct = 58; dst_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  dst_stall_pct = 58; end
                default: begin src_idle_pct = 32; dst_stall_pct = 32; end
            endcase
            for (int i = 0; i < 60; i++)
                send_bone(make_bone($urandom_range(4) == 0, 20, $urandom_range(11) == 0));
        end
        src_idle_pct = 0;
        dst_stall_pct = 0;
        drain();

        $display("covered %0d bones (%0d results checked), incl. roots, deep chains, wrap",
                 sent, sb.checked);
        $display("extreme values, saturation and idle/stall mixes on both channels");
        if (sb.fail_count == 0)
            $display("bone_hierarchy_transform test passed");
        else
            $display("bone_hierarchy_transform test failed");
        $finish;
    end
endmodule
